FILE: src/integer_alu_with_power_core_defines.svh
// Assertion helpers for the integer ALU core.
// Both expect aclk and aresetn in the scope where they are used.
`ifndef INTEGER_ALU_WITH_POWER_CORE_DEFINES_SVH
`define INTEGER_ALU_WITH_POWER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define IALU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define IALU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ialu_pkg.sv
package ialu_pkg;

    // bits of the multiplier operand consumed per multiply step
    localparam int MUL_DIGIT = 16;

    // operation codes; the two remaining codes are invalid
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_POW = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    // how the decoded beat gets its result
    typedef enum logic [1:0] {
        JOB_QUICK = 2'd0,
        JOB_DIV   = 2'd1,
        JOB_MUL   = 2'd2,
        JOB_POW   = 2'd3
    } job_t;

    // multiplier operand pair: a*b, acc*base, base*base
    typedef enum logic [1:0] {
        MSEL_AB  = 2'd0,
        MSEL_ACC = 2'd1,
        MSEL_SQR = 2'd2
    } msel_t;

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  quick;
        logic  div_init;
        logic  div_step;
        logic  div_fin;
        logic  mul_init;
        msel_t mul_sel;
        logic  mul_step;
        logic  mul_fin;
        logic  pow_init;
        logic  acc_load;
        logic  base_load;
        logic  e_shift;
        logic  pow_fin;
        logic  pow_sat;
        logic  out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        job_t job;
        logic e_bit0;
        logic e_next_zero;
        logic mul_ovf;
    } sts_t;

endpackage

FILE: src/ialu_dp.sv
module ialu_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic [2:0]            in_op,
    input  logic [DATA_WIDTH-1:0] in_a,
    input  logic [DATA_WIDTH-1:0] in_b,
    input  ialu_pkg::cmd_t        cmd,
    output ialu_pkg::sts_t        sts,
    output logic [DATA_WIDTH-1:0] out_result,
    output logic [1:0]            out_status
);

    localparam int W  = DATA_WIDTH;
    localparam int D  = ialu_pkg::MUL_DIGIT;
    localparam int S  = (W + D - 1) / D;
    localparam int YW = S * D;
    localparam int PW = YW + W;
    localparam int EW = $clog2(W);
    localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX_W = ~MIN_W;

    logic [2:0]        op_reg;
    logic [W-1:0]      a_reg, b_reg;
    logic [W-1:0]      res_reg, out_res_reg;
    ialu_pkg::status_t st_reg, out_st_reg;
    logic [W-1:0]      quo_reg, rem_reg;
    logic [W-1:0]      acc_reg, base_reg;
    logic [EW-1:0]     e_reg;
    logic              neg_reg;
    logic [W-1:0]      mx_reg;
    logic [YW-1:0]     my_reg;
    logic [PW-1:0]     prod_reg;

    logic              a_neg, b_neg, pow_neg;
    logic [W-1:0]      a_mag, b_mag;
    logic [W-1:0]      q_res;
    ialu_pkg::status_t q_st;
    ialu_pkg::job_t    job;
    logic [W-1:0]      mx_sel, my_sel;
    logic [D-1:0]      digit;
    logic [W+D-1:0]    pp;
    logic [W:0]        div_sh, div_diff;
    logic [W-1:0]      div_res, limit;

    // operand signs and magnitudes
    assign a_neg   = a_reg[W-1];
    assign b_neg   = b_reg[W-1];
    assign a_mag   = a_neg ? ({W{1'b0}} - a_reg) : a_reg;
    assign b_mag   = b_neg ? ({W{1'b0}} - b_reg) : b_reg;
    assign pow_neg = a_neg & b_reg[0];

    // decode: quick results and special cases
    always_comb begin
        q_res = '0;
        q_st  = ialu_pkg::ST_OK;
        job   = ialu_pkg::JOB_QUICK;
        case (op_reg)
            ialu_pkg::OP_ADD: q_res = a_reg + b_reg;
            ialu_pkg::OP_SUB: q_res = a_reg - b_reg;
            ialu_pkg::OP_MUL: job = ialu_pkg::JOB_MUL;
            ialu_pkg::OP_DIV, ialu_pkg::OP_MOD: begin
                if (b_reg == '0) begin
                    q_st = ialu_pkg::ST_DIVZERO;
                end else if (a_reg == MIN_W && (&b_reg)) begin
                    q_st = ialu_pkg::ST_OVERFLOW;
                end else begin
                    job = ialu_pkg::JOB_DIV;
                end
            end
            ialu_pkg::OP_POW: begin
                if (b_neg) begin
                    // truncated reciprocal
                    if (a_reg == W'(1)) begin
                        q_res = W'(1);
                    end else if (&a_reg) begin
                        q_res = b_reg[0] ? {W{1'b1}} : W'(1);
                    end else if (a_reg == '0) begin
                        q_st = ialu_pkg::ST_DIVZERO;
                    end
                end else if (b_reg == '0) begin
                    q_res = W'(1);
                end else if (a_mag <= W'(1)) begin
                    q_res = pow_neg ? ({W{1'b0}} - a_mag) : a_mag;
                end else if (b_reg >= W'(W)) begin
                    // base magnitude of at least two: exceeds the word for sure
                    q_res = pow_neg ? MIN_W : MAX_W;
                    q_st  = ialu_pkg::ST_OVERFLOW;
                end else begin
                    job = ialu_pkg::JOB_POW;
                end
            end
            default: q_st = ialu_pkg::ST_INVALID;
        endcase
    end

    // multiplier operand select
    always_comb begin
        case (cmd.mul_sel)
            ialu_pkg::MSEL_ACC: begin
                mx_sel = acc_reg;
                my_sel = base_reg;
            end
            ialu_pkg::MSEL_SQR: begin
                mx_sel = base_reg;
                my_sel = base_reg;
            end
            default: begin
                mx_sel = a_reg;
                my_sel = b_reg;
            end
        endcase
    end

    // digit-serial product, top digit first
    assign digit = my_reg[YW-1 -: D];
    assign pp    = mx_reg * digit;
    assign limit = neg_reg ? MIN_W : MAX_W;

    // restoring divide step
    assign div_sh   = {rem_reg, quo_reg[W-1]};
    assign div_diff = div_sh - {1'b0, base_reg};
    always_comb begin
        if (op_reg == ialu_pkg::OP_DIV) begin
            div_res = (a_neg ^ b_neg) ? ({W{1'b0}} - quo_reg) : quo_reg;
        end else begin
            div_res = a_neg ? ({W{1'b0}} - rem_reg) : rem_reg;
        end
    end

    // input beat
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_op;
            a_reg  <= in_a;
            b_reg  <= in_b;
        end
    end

    // multiplier registers
    always_ff @(posedge aclk) begin
        if (cmd.mul_init) begin
            mx_reg   <= mx_sel;
            my_reg   <= YW'(my_sel);
            prod_reg <= '0;
        end else if (cmd.mul_step) begin
            my_reg   <= my_reg << D;
            prod_reg <= (prod_reg << D) + PW'(pp);
        end
    end

    // divider registers
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            quo_reg <= a_mag;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            if (!div_diff[W]) begin
                rem_reg <= div_diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= div_sh[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    // power loop registers; base also holds the divisor magnitude
    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            base_reg <= b_mag;
        end else if (cmd.pow_init) begin
            base_reg <= a_mag;
        end else if (cmd.base_load) begin
            base_reg <= prod_reg[W-1:0];
        end
        if (cmd.pow_init) begin
            acc_reg <= W'(1);
            e_reg   <= b_reg[EW-1:0];
            neg_reg <= pow_neg;
        end else begin
            if (cmd.acc_load) begin
                acc_reg <= prod_reg[W-1:0];
            end
            if (cmd.e_shift) begin
                e_reg <= e_reg >> 1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.quick) begin
            res_reg <= q_res;
            st_reg  <= q_st;
        end else if (cmd.div_fin) begin
            res_reg <= div_res;
            st_reg  <= ialu_pkg::ST_OK;
        end else if (cmd.mul_fin) begin
            res_reg <= prod_reg[W-1:0];
            st_reg  <= ialu_pkg::ST_OK;
        end else if (cmd.pow_fin) begin
            res_reg <= neg_reg ? ({W{1'b0}} - acc_reg) : acc_reg;
            st_reg  <= ialu_pkg::ST_OK;
        end else if (cmd.pow_sat) begin
            res_reg <= limit;
            st_reg  <= ialu_pkg::ST_OVERFLOW;
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_res_reg <= res_reg;
            out_st_reg  <= st_reg;
        end
    end

    assign sts.job         = job;
    assign sts.e_bit0      = e_reg[0];
    assign sts.e_next_zero = (e_reg >> 1) == '0;
    assign sts.mul_ovf     = prod_reg > PW'(limit);
    assign out_result      = out_res_reg;
    assign out_status      = out_st_reg;

endmodule

FILE: src/ialu_ctrl.sv
module ialu_ctrl #(
    parameter int DATA_WIDTH = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  ialu_pkg::sts_t sts,
    output ialu_pkg::cmd_t cmd
);

    localparam int W  = DATA_WIDTH;
    localparam int D  = ialu_pkg::MUL_DIGIT;
    localparam int S  = (W + D - 1) / D;
    localparam int CW = $clog2(W);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_DIV    = 9'b000000100,
        S_DIVFIN = 9'b000001000,
        S_MUL    = 9'b000010000,
        S_MULEND = 9'b000100000,
        S_PTEST  = 9'b001000000,
        S_PSHIFT = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    ialu_pkg::msel_t dest_reg, dest_next;
    logic            ov_reg, ov_next;

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dest_next  = dest_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        if (ov_reg && m_ready) begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.job)
                    ialu_pkg::JOB_DIV: begin
                        cmd.div_init = 1'b1;
                        cnt_next     = '0;
                        state_next   = S_DIV;
                    end
                    ialu_pkg::JOB_MUL: begin
                        cmd.mul_init = 1'b1;
                        cmd.mul_sel  = ialu_pkg::MSEL_AB;
                        dest_next    = ialu_pkg::MSEL_AB;
                        cnt_next     = '0;
                        state_next   = S_MUL;
                    end
                    ialu_pkg::JOB_POW: begin
                        cmd.pow_init = 1'b1;
                        state_next   = S_PTEST;
                    end
                    default: begin
                        cmd.quick  = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1)) begin
                    state_next = S_DIVFIN;
                end
            end
            S_DIVFIN: begin
                cmd.div_fin = 1'b1;
                state_next  = S_DONE;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_reg == CW'(S - 1)) begin
                    state_next = S_MULEND;
                end
            end
            S_MULEND: begin
                case (dest_reg)
                    ialu_pkg::MSEL_ACC: begin
                        if (sts.mul_ovf) begin
                            cmd.pow_sat = 1'b1;
                            state_next  = S_DONE;
                        end else begin
                            cmd.acc_load = 1'b1;
                            state_next   = S_PSHIFT;
                        end
                    end
                    ialu_pkg::MSEL_SQR: begin
                        if (sts.mul_ovf) begin
                            cmd.pow_sat = 1'b1;
                            state_next  = S_DONE;
                        end else begin
                            cmd.base_load = 1'b1;
                            state_next    = S_PTEST;
                        end
                    end
                    default: begin
                        cmd.mul_fin = 1'b1;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_PTEST: begin
                // multiply into acc on a set exponent bit
                if (sts.e_bit0) begin
                    cmd.mul_init = 1'b1;
                    cmd.mul_sel  = ialu_pkg::MSEL_ACC;
                    dest_next    = ialu_pkg::MSEL_ACC;
                    cnt_next     = '0;
                    state_next   = S_MUL;
                end else begin
                    state_next = S_PSHIFT;
                end
            end
            S_PSHIFT: begin
                cmd.e_shift = 1'b1;
                if (sts.e_next_zero) begin
                    cmd.pow_fin = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    cmd.mul_init = 1'b1;
                    cmd.mul_sel  = ialu_pkg::MSEL_SQR;
                    dest_next    = ialu_pkg::MSEL_SQR;
                    cnt_next     = '0;
                    state_next   = S_MUL;
                end
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!ov_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            dest_reg  <= ialu_pkg::MSEL_AB;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dest_reg  <= dest_next;
            ov_reg    <= ov_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = ov_reg;

endmodule

FILE: src/integer_alu_with_power_core.sv
// Add, sub, errors and trivial powers are decoded directly; mul runs the multiplier;
// div and mod run the divider (one quotient bit per cycle); pow reuses the
// 16-bit-per-cycle multiplier for every squaring and every accumulator multiply.
// One beat in flight: the next input beat is taken the cycle after the result moves to
// the output register, which may still be waiting on m_axis_tready.
// Reset: synchronous, active-low aresetn clears the sequencer and output valid.
`include "integer_alu_with_power_core_defines.svh"

module integer_alu_with_power_core #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // op[2:0], operand_a, operand_b, zero pad
    input  logic [((3+2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // result, status[1:0], zero pad
    output logic [((DATA_WIDTH+2+7)/8)*8-1:0]        m_axis_tdata
);

    localparam int W     = DATA_WIDTH;
    localparam int OUT_W = ((W + 2 + 7) / 8) * 8;

    ialu_pkg::cmd_t ctrl_cmd;
    ialu_pkg::sts_t dp_sts;
    logic [W-1:0]   out_result;
    logic [1:0]     out_status;
    logic           in_beat, out_free, out_err;

    ialu_ctrl #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (dp_sts),
        .cmd     (ctrl_cmd)
    );

    ialu_dp #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .in_op      (s_axis_tdata[2:0]),
        .in_a       (s_axis_tdata[W+2:3]),
        .in_b       (s_axis_tdata[2*W+2:W+3]),
        .cmd        (ctrl_cmd),
        .sts        (dp_sts),
        .out_result (out_result),
        .out_status (out_status)
    );

    assign m_axis_tdata = OUT_W'({out_status, out_result});

    // checks
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign out_err  = m_axis_tvalid && (out_status == ialu_pkg::ST_DIVZERO ||
                                        out_status == ialu_pkg::ST_INVALID);

    `IALU_ASSERT_NEXT(a_busy_after_beat, in_beat, !s_axis_tready, "beat taken while busy")
    `IALU_ASSERT_NOW(a_no_overwrite, ctrl_cmd.out_load, out_free, "result overwritten")
    `IALU_ASSERT_NOW(a_error_zero, out_err, out_result == '0, "error result not zero")

endmodule
